/* design/mbs_pkg.sv */
// Package for the median-by-sorting unit: sizes, controller state type,
// and the command and status structs that join controller and datapath.
// No dependencies.
package mbs_pkg;

	localparam int MBS_MAX_ITEMS = 64;
	localparam int MBS_DATA_W    = 32;
	localparam int MBS_COUNT_W   = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_MED_RD,
		ST_MED_CALC
	} mbs_state_t;

	// Where the memory read ports point in the coming cycle.
	typedef enum logic [1:0] {
		RD_LOAD,
		RD_SHIFT,
		RD_MED
	} mbs_rd_sel_t;

	typedef struct packed {
		logic        load;
		mbs_rd_sel_t rd_sel;
		logic        shift;
		logic        place;
		logic        drop;
		logic        emit;
	} mbs_cmd_t;

	typedef struct packed {
		logic full;
		logic pos_zero;
		logic greater;
		logic last;
	} mbs_status_t;

endpackage

/* design/mbs_ctrl.sv */
// Controller of the median-by-sorting unit: request handshake, insertion
// sequencing, median read-out and the output valid flag.
// Depends on mbs_pkg.
module mbs_ctrl
	import mbs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_last,
	output logic        in_ready,
	output logic        out_valid,
	input  logic        out_ready,
	input  mbs_status_t status,
	output mbs_cmd_t    cmd
);

	mbs_state_t state_q, state_next;
	logic       out_valid_q;
	logic       accept;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (!status.full) begin
						state_next = ST_SHIFT;
					end else if (in_last) begin
						state_next = ST_MED_RD;
					end
				end
			end
			ST_SHIFT: begin
				if (status.pos_zero || !status.greater) begin
					state_next = status.last ? ST_MED_RD : ST_IDLE;
				end
			end
			ST_MED_RD: begin
				state_next = ST_MED_CALC;
			end
			ST_MED_CALC: begin
				if (!out_valid_q || out_ready) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.rd_sel = RD_LOAD;
		case (state_q)
			ST_IDLE: begin
				cmd.load = accept;
				cmd.drop = accept && status.full;
			end
			ST_SHIFT: begin
				if (status.pos_zero || !status.greater) begin
					cmd.place = 1'b1;
				end else begin
					cmd.shift  = 1'b1;
					cmd.rd_sel = RD_SHIFT;
				end
			end
			ST_MED_RD: begin
				cmd.rd_sel = RD_MED;
			end
			ST_MED_CALC: begin
				// Keep the middle entries on the read ports while the result waits.
				cmd.rd_sel = RD_MED;
				cmd.emit   = !out_valid_q || out_ready;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_next;
			out_valid_q <= cmd.emit || (out_valid_q && !out_ready);
		end
	end

endmodule

/* design/mbs_dpath.sv */
// Datapath of the median-by-sorting unit: sorted value memory, fill count,
// insertion position, median arithmetic and the result register.
// Depends on mbs_pkg.
module mbs_dpath
	import mbs_pkg::*;
#(
	parameter int MAX_ITEMS = MBS_MAX_ITEMS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [MBS_DATA_W-1:0]   in_value,
	input  logic                    in_last,
	input  mbs_cmd_t                cmd,
	output mbs_status_t             status,
	output logic [MBS_DATA_W-1:0]   out_median,
	output logic [MBS_COUNT_W-1:0]  out_count,
	output logic                    out_ovf
);

	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;

	logic [MBS_DATA_W-1:0] mem [MAX_ITEMS];
	logic [MBS_DATA_W-1:0] rd_a_q, rd_b_q;
	logic [MBS_DATA_W-1:0] value_q;
	logic                  last_q;
	logic [AW-1:0]         pos_q;
	logic [CW-1:0]         fill_q;
	logic                  drop_q;

	logic [AW-1:0]         rd_a_addr, rd_b_addr, wr_addr;
	logic [MBS_DATA_W-1:0] wr_data;
	logic                  wr_en;
	logic [CW-1:0]         half_w;
	logic [MBS_DATA_W:0]   pair_sum;
	logic [MBS_DATA_W:0]   pair_adj;
	logic [MBS_DATA_W-1:0] median_w;
	logic [CW+MBS_COUNT_W-1:0] count_ext;

	assign half_w    = fill_q >> 1;
	assign count_ext = {{MBS_COUNT_W{1'b0}}, fill_q};

	always_comb begin
		rd_b_addr = half_w[AW-1:0];
		case (cmd.rd_sel)
			RD_LOAD:  rd_a_addr = fill_q[AW-1:0] - AW'(1);
			RD_SHIFT: rd_a_addr = pos_q - AW'(2);
			RD_MED:   rd_a_addr = half_w[AW-1:0] - AW'(1);
			default:  rd_a_addr = '0;
		endcase
	end

	assign wr_en   = cmd.shift || cmd.place;
	assign wr_addr = pos_q;
	assign wr_data = cmd.shift ? rd_a_q : value_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_a_addr];
		rd_b_q <= mem[rd_b_addr];
	end

	// Even count: mean of the two middle values, rounded toward zero.
	assign pair_sum = {rd_a_q[MBS_DATA_W-1], rd_a_q} + {rd_b_q[MBS_DATA_W-1], rd_b_q};
	assign pair_adj = pair_sum + {{MBS_DATA_W{1'b0}}, pair_sum[MBS_DATA_W]};
	assign median_w = fill_q[0] ? rd_b_q : pair_adj[MBS_DATA_W:1];

	assign status.full     = (fill_q == CW'(MAX_ITEMS));
	assign status.pos_zero = (pos_q == '0);
	assign status.greater  = ($signed(rd_a_q) > $signed(value_q));
	assign status.last     = last_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			value_q <= in_value;
			last_q  <= in_last;
			pos_q   <= fill_q[AW-1:0];
		end else if (cmd.shift) begin
			pos_q <= pos_q - AW'(1);
		end
		if (cmd.emit) begin
			out_median <= median_w;
			out_count  <= count_ext[MBS_COUNT_W-1:0];
			out_ovf    <= drop_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			drop_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				fill_q <= '0;
				drop_q <= 1'b0;
			end else begin
				if (cmd.place) begin
					fill_q <= fill_q + CW'(1);
				end
				if (cmd.drop) begin
					drop_q <= 1'b1;
				end
			end
		end
	end

endmodule

/* design/median_by_sorting_unit.sv */
// Top level of the median-by-sorting unit: stream ports, controller and
// datapath. Depends on mbs_pkg, mbs_ctrl and mbs_dpath.
//
//  Channel  | Direction | Contents
//  ---------+-----------+------------------------------------------------
//  s_*      | in        | one value of a set; tlast marks the last value
//  m_*      | out       | median, kept count; tuser carries the overflow
//
// An accepted request is loaded, each kept value greater than it moves up by
// one place, and the value is stored, in turn, set by the single write port
// of the value memory; no new value is taken until it is stored. A request
// that finds the store full is dropped and marks the overflow. After the last
// value of a set, the two middle entries are read and the median is formed.
// Reset clears the fill count, the overflow mark and the controller; the
// value memory is not cleared, only written entries are read. A result waits
// in the output register while m_tready is low; a new set is loaded
// meanwhile, and only the next median waits for the register.
module median_by_sorting_unit
	import mbs_pkg::*;
#(
	parameter int MAX_ITEMS = MBS_MAX_ITEMS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] sample_value
	input  logic        s_tlast,   // last_of_set
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] median_value, [38:32] set_count, [39] zero
	output logic        m_tuser    // overflow_flag
);

	mbs_cmd_t                cmd;
	mbs_status_t             status;
	logic [MBS_DATA_W-1:0]   median;
	logic [MBS_COUNT_W-1:0]  count;
	logic                    ovf;

	mbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	mbs_dpath #(
		.MAX_ITEMS (MAX_ITEMS)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_value   (s_tdata),
		.in_last    (s_tlast),
		.cmd        (cmd),
		.status     (status),
		.out_median (median),
		.out_count  (count),
		.out_ovf    (ovf)
	);

	// Result fields packed from the lowest bit up, padded to whole bytes.
	assign m_tdata = {1'b0, count, median};
	assign m_tuser = ovf;

endmodule

/* design/mbs_checker.sv */
// Port-level checks for the median-by-sorting unit, attached by bind.
// Depends on median_by_sorting_unit.
module mbs_checker #(
	parameter int MAX_ITEMS = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [31:0] s_tdata,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tuser
);

	// A stalled result keeps its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// After the last value of a set the unit is busy forming the median.
	a_busy_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready)
		else $error("request taken right after the last value of a set");

	// A result never appears in the cycle right after a request.
	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !$rose(m_tvalid))
		else $error("result appeared too early");

	// A reported set is never empty.
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (MAX_ITEMS > 127) || (m_tdata[38:32] != 7'd0))
		else $error("empty set reported");

endmodule

bind median_by_sorting_unit mbs_checker #(.MAX_ITEMS(MAX_ITEMS)) u_mbs_checker (.*);

/* tb/sv/median_by_sorting_unit_tb.sv */
// Self-checking testbench for median_by_sorting_unit: drives sets of signed values,
// predicts each median with a sorted-row model, and checks every result request.
// Depends on mbs_pkg and median_by_sorting_unit.
module median_by_sorting_unit_tb;
	import mbs_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request accepted on either side
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
	localparam int SETTLE_CYCLES  = 2 * MBS_MAX_ITEMS + 16;

	typedef struct {
		logic signed [31:0] median;
		logic [6:0]         count;
		logic               overflow;
	} median_result_t;

	// How the values of one random set are drawn.
	typedef enum {
		VAL_WIDE,
		VAL_NARROW,
		VAL_EDGES
	} value_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tuser;

	median_by_sorting_unit u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always #4 clk = ~clk;

	// Predictor state: the kept values of the open set, ascending, and the drop mark.
	int             kept_values[$];
	bit             set_dropped;
	median_result_t expected_medians[$];

	int error_count;
	int values_sent;
	int sets_sent;
	int overflow_sets;
	int largest_set;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_requests;
	int hold_seen;
	int hold_left;
	int quiet_cycles;

	// Insert after every kept value less than or equal to the new one; close the set
	// and queue its median on the last value.
	function automatic void predict_sample(int value, bit last);
		int             pos;
		int             n;
		longint         pair_sum;
		median_result_t res;
		if (kept_values.size() < MBS_MAX_ITEMS) begin
			pos = kept_values.size();
			while (pos > 0 && kept_values[pos - 1] > value)
				pos--;
			kept_values.insert(pos, value);
		end else begin
			set_dropped = 1'b1;
		end
		if (!last)
			return;
		n = kept_values.size();
		if (n % 2 == 1) begin
			res.median = kept_values[n / 2];
		end else begin
			// Exact sum, then signed division, which truncates toward zero.
			pair_sum = longint'(kept_values[n / 2 - 1]) + longint'(kept_values[n / 2]);
			res.median = 32'(pair_sum / 2);
		end
		res.count    = 7'(n);
		res.overflow = set_dropped;
		expected_medians.push_back(res);
		sets_sent++;
		if (set_dropped)
			overflow_sets++;
		if (n > largest_set)
			largest_set = n;
		kept_values.delete();
		set_dropped = 1'b0;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("[%0t] mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
		error_count++;
	endtask

	// Offers one value and returns at the edge where it was accepted; valid stays high
	// so that a following call can present the next request without a gap.
	task automatic offer_sample(int value, bit last);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= value;
		s_tlast  <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		values_sent++;
		predict_sample(value, last);
	endtask

	task automatic offer_set(int values[$]);
		foreach (values[i])
			offer_sample(values[i], i == values.size() - 1);
	endtask

	// Sender pause: nothing offered until every expected median has come back.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_medians.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic int rand_sample(value_mode_t mode);
		case (mode)
			VAL_NARROW: return $urandom_range(0, 16) - 8;
			VAL_EDGES: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7fff_ffff;
					2: return 32'h8000_0000 + $urandom_range(0, 3);
					default: return 32'h7fff_ffff - $urandom_range(0, 3);
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Mostly short sets, some long ones, a few that run past the store.
	function automatic int rand_set_size();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 45)
			return $urandom_range(1, 4);
		if (pick < 80)
			return $urandom_range(5, 16);
		if (pick < 95)
			return $urandom_range(17, MBS_MAX_ITEMS);
		return $urandom_range(MBS_MAX_ITEMS + 1, MBS_MAX_ITEMS + 8);
	endfunction

	task automatic send_random_set(int size);
		value_mode_t mode;
		mode = value_mode_t'($urandom_range(0, 2));
		for (int i = 0; i < size; i++)
			offer_sample(rand_sample(mode), i == size - 1);
	endtask

	// Single values, both extremes, the even case with truncation toward zero on
	// either sign, duplicates, and a descending set.
	task automatic test_directed_extremes();
		offer_set('{5});
		offer_set('{32'h7fff_ffff});
		offer_set('{32'h8000_0000});
		offer_set('{32'h7fff_ffff, 32'h8000_0000});
		offer_set('{32'h8000_0000, 32'h8000_0000});
		offer_set('{32'h7fff_ffff, 32'h7fff_ffff});
		offer_set('{-3, 0});
		offer_set('{3, 0});
		offer_set('{2, 2, 1, 3, 2});
		offer_set('{4, 3, 2, 1});
		wait_drained();
	endtask

	// A set that just fills the store, one whose last value is dropped, and one that
	// drops several values, the last among them.
	task automatic test_overflow_sets();
		send_random_set(MBS_MAX_ITEMS);
		send_random_set(MBS_MAX_ITEMS + 1);
		send_random_set(MBS_MAX_ITEMS + 6);
		wait_drained();
	endtask

	// The receiver holds off while short sets keep coming, so the output register
	// fills and the input stalls; then the sender pauses until all is drained.
	task automatic test_output_hold_off();
		hold_requests++;
		for (int i = 0; i < 12; i++)
			send_random_set($urandom_range(2, 4));
		wait_drained();
	endtask

	task automatic test_random_sets(int n_values);
		int target;
		target = values_sent + n_values;
		while (values_sent < target)
			send_random_set(rand_set_size());
		wait_drained();
	endtask

	// Receiver: random idling, overridden by a hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen <= hold_requests;
			hold_left <= HOLD_CYCLES;
			m_tready  <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// Result checker: compares each accepted result with the oldest expectation.
	always @(posedge clk) begin
		median_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_medians.size() == 0) begin
				report_mismatch("unexpected result, median", $signed(m_tdata[31:0]), 0);
			end else begin
				want = expected_medians.pop_front();
				if (m_tdata[31:0] !== want.median)
					report_mismatch("median", $signed(m_tdata[31:0]), want.median);
				if (m_tdata[38:32] !== want.count)
					report_mismatch("set count", m_tdata[38:32], want.count);
				if (m_tuser !== want.overflow)
					report_mismatch("overflow flag", m_tuser, want.overflow);
				if (m_tdata[39] !== 1'b0)
					report_mismatch("tdata pad bit", m_tdata[39], 0);
			end
		end
	end

	// Watchdog: ends the run when no request moves on either side for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] timeout: no request accepted for %0d cycles",
				$realtime, WATCHDOG_LIMIT);
			$display("median_by_sorting_unit_tb: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_overflow_sets();
		test_output_hold_off();

		send_idle_pct = 16;
		recv_idle_pct = 67;
		test_random_sets(270);
		send_idle_pct = 67;
		recv_idle_pct = 16;
		test_random_sets(270);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_sets(270);

		$display("Covered %0d values in %0d sets, %0d sets over capacity, largest kept set %0d.",
			values_sent, sets_sent, overflow_sets, largest_set);
		$display("Idling on either side, a long output hold-off and drained pauses included.");
		if (error_count == 0)
			$display("median_by_sorting_unit_tb: PASS");
		else
			$display("median_by_sorting_unit_tb: FAIL");
		$finish;
	end

endmodule

/* filelist.f */
design/mbs_pkg.sv
design/mbs_ctrl.sv
design/mbs_dpath.sv
design/median_by_sorting_unit.sv
design/mbs_checker.sv
tb/sv/median_by_sorting_unit_tb.sv
